// ===== rtl/core/rsum_pkg.sv =====
// Shared types and constants for the range sum block.
// Used by the interfaces, the log chain, its cells and the top level.
package rsum_pkg;

  localparam int unsigned IDX_W         = 10;
  localparam int unsigned AMT_W         = 32;
  localparam int unsigned SUM_W         = 48;
  localparam int unsigned DELTA_W       = AMT_W + 1;
  localparam int unsigned ACC_W         = SUM_W + 2;
  localparam int unsigned ELEMENTS_DEF  = 1024;
  localparam int unsigned LOG_DEPTH_DEF = 1024;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SUM  = 2'd1,
    OP_GIVE = 2'd2,
    OP_TAKE = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [DELTA_W-1:0] delta;
  } log_entry_t;

  typedef struct packed {
    logic push;
    logic rotate;
  } chain_ctrl_t;

endpackage

// ===== rtl/core/rsum_req_if.sv =====
// Request channel of the range sum block: valid, ready and one operation.
// Depends on rsum_pkg for the field widths.
interface rsum_req_if;
  import rsum_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] start_index;
  logic [IDX_W-1:0] end_index;
  logic [AMT_W-1:0] amount;

  modport source (output valid, opcode, start_index, end_index, amount, input ready);
  modport sink   (input valid, opcode, start_index, end_index, amount, output ready);
endinterface

// ===== rtl/core/rsum_rsp_if.sv =====
// Response channel of the range sum block: valid, ready and one sum result.
// Depends on rsum_pkg for the field widths.
interface rsum_rsp_if;
  import rsum_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic                    log_overflowed;

  modport source (output valid, range_sum, log_overflowed, input ready);
  modport sink   (input valid, range_sum, log_overflowed, output ready);
endinterface

// ===== rtl/core/range_sum_with_point_updates.sv =====
// Range sum block with a prefix table and a log of point updates.
// Depends on rsum_pkg, rsum_req_if, rsum_rsp_if and rsum_log_chain.
//
// Load, give and take requests are taken one per cycle while the block is
// idle. A sum request passes through ST_READ, which forms the prefix difference
// from the table entries read at acceptance, ST_WALK, in which the update log
// chain rotates once past the accumulator, one entry per cycle, and ST_FINISH,
// which saturates and registers the result and stretches while an earlier
// result still waits. No new request is taken meanwhile; the next one can be
// taken once the result is registered.
// The result sits in an output register, so the next request is taken while
// a result still waits. There is no clearing pass after reset.
module range_sum_with_point_updates #(
  parameter int unsigned ELEMENTS  = rsum_pkg::ELEMENTS_DEF,
  parameter int unsigned LOG_DEPTH = rsum_pkg::LOG_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsum_req_if.sink  req_i,
  rsum_rsp_if.source rsp_o
);
  import rsum_pkg::*;

  localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam logic [16:0] ELEM_C = 17'(ELEMENTS);
  localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
  localparam logic [CW-1:0] LAST_STEP = CW'(LOG_DEPTH - 1);
  localparam logic [SUM_W:0] TOTAL_MAX = {2'b00, {(SUM_W-1){1'b1}}};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  logic             accept;
  logic             is_load, is_sum, is_give, is_take;
  logic [16:0]      s_ext, e_ext, sm1_ext;
  logic [16:0]      ra_e, ra_s;
  logic             we;

  logic [SUM_W-1:0] mem [ELEMENTS];
  logic [SUM_W-1:0] rd_e_q, rd_s_q;

  logic [SUM_W-1:0] total_q, total_d;
  logic [SUM_W:0]   total_sum;

  logic [IDX_W-1:0] s_q, e_q;
  logic             s_zero_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SUM_W:0]   diff;
  logic [CW-1:0]    step_q, step_d;

  chain_ctrl_t      ctrl;
  log_entry_t       push_entry;
  log_entry_t       tail;
  logic [CW-1:0]    count;
  logic             overflow;
  logic             hit;

  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_ovf_q;
  logic                    out_free;
  logic                    finish;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign is_load     = (req_i.opcode == OP_LOAD);
  assign is_sum      = (req_i.opcode == OP_SUM);
  assign is_give     = (req_i.opcode == OP_GIVE);
  assign is_take     = (req_i.opcode == OP_TAKE);

  assign s_ext   = {7'b0, req_i.start_index};
  assign e_ext   = {7'b0, req_i.end_index};
  assign sm1_ext = s_ext - 17'd1;
  assign ra_e    = (e_ext >= ELEM_C) ? (ELEM_C - 17'd1) : e_ext;
  assign ra_s    = (sm1_ext >= ELEM_C) ? (ELEM_C - 17'd1) : sm1_ext;
  assign we      = accept & is_load & (s_ext < ELEM_C);

  assign total_sum = {1'b0, total_q} + (SUM_W+1)'(req_i.amount);
  assign total_d   = (total_sum > TOTAL_MAX) ? TOTAL_MAX[SUM_W-1:0] : total_sum[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[s_ext[AW-1:0]] <= total_d;
    end
    rd_e_q <= mem[ra_e[AW-1:0]];
    rd_s_q <= mem[ra_s[AW-1:0]];
  end

  assign ctrl.push   = accept & (is_give | is_take);
  assign ctrl.rotate = (state_q == ST_WALK);
  assign push_entry.idx   = req_i.start_index;
  assign push_entry.delta = is_give ? $signed({1'b0, req_i.amount})
                                    : -$signed({1'b0, req_i.amount});

  rsum_log_chain #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_log_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .push_entry_i (push_entry),
    .tail_o       (tail),
    .count_o      (count),
    .overflow_o   (overflow)
  );

  assign diff = $signed({1'b0, rd_e_q})
              - (s_zero_q ? '0 : $signed({1'b0, rd_s_q}));
  assign hit  = (step_q >= (DEPTH_C - count))
              & (tail.idx >= s_q) & (tail.idx <= e_q);

  assign out_free = ~out_valid_q | rsp_o.ready;
  assign finish   = (state_q == ST_FINISH) & out_free;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_sum) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        acc_d   = ACC_W'(diff);
        step_d  = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (hit) begin
          acc_d = acc_q + ACC_W'($signed(tail.delta));
        end
        step_d = step_q + CW'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept && is_load) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    step_q <= step_d;
    if (accept && is_sum) begin
      s_q      <= req_i.start_index;
      e_q      <= req_i.end_index;
      s_zero_q <= (req_i.start_index == '0);
    end
    if (finish) begin
      out_ovf_q <= overflow;
      if (acc_q > $signed(ACC_W'($signed(SUM_MAX)))) begin
        out_sum_q <= $signed(SUM_MAX);
      end else if (acc_q < $signed(ACC_W'($signed(SUM_MIN)))) begin
        out_sum_q <= $signed(SUM_MIN);
      end else begin
        out_sum_q <= acc_q[SUM_W-1:0];
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.range_sum      = out_sum_q;
  assign rsp_o.log_overflowed = out_ovf_q;
endmodule

// ===== rtl/core/rsum_cell.sv =====
// One cell of the update log chain: holds one logged entry.
// Depends on rsum_pkg for the entry type.
module rsum_cell (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  rsum_pkg::log_entry_t entry_i,
  output rsum_pkg::log_entry_t entry_o
);
  import rsum_pkg::*;

  log_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
endmodule

// ===== rtl/core/rsum_log_chain.sv =====
// Update log built as a row of rsum_cell, with fill count and overflow flag.
// Depends on rsum_pkg and rsum_cell.
module rsum_log_chain #(
  parameter int unsigned LOG_DEPTH = rsum_pkg::LOG_DEPTH_DEF,
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsum_pkg::chain_ctrl_t ctrl_i,
  input  rsum_pkg::log_entry_t  push_entry_i,
  output rsum_pkg::log_entry_t  tail_o,
  output logic [CW-1:0]         count_o,
  output logic                  overflow_o
);
  import rsum_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);

  log_entry_t    cell_q [LOG_DEPTH];
  log_entry_t    head_d;
  logic          shift;
  logic          room;
  logic [CW-1:0] count_q, count_d;
  logic          overflow_q, overflow_d;

  assign room  = (count_q != DEPTH_C);
  assign shift = ctrl_i.rotate | (ctrl_i.push & room);
  assign head_d = ctrl_i.rotate ? cell_q[LOG_DEPTH-1] : push_entry_i;

  for (genvar k = 0; k < LOG_DEPTH; k++) begin : g_cell
    rsum_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i ((k == 0) ? head_d : cell_q[(k == 0) ? 0 : k-1]),
      .entry_o (cell_q[k])
    );
  end

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (ctrl_i.push) begin
      if (room) begin
        count_d = count_q + CW'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  assign tail_o     = cell_q[LOG_DEPTH-1];
  assign count_o    = count_q;
  assign overflow_o = overflow_q;
endmodule

// ===== rtl/core/rsum_checker.sv =====
// Port-level assertions for the range sum block and the bind that attaches them.
// Depends on rsum_pkg and range_sum_with_point_updates.
module rsum_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic [1:0]                      in_opcode_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [rsum_pkg::SUM_W-1:0] out_sum_i,
  input logic                            out_ovf_i
);
  import rsum_pkg::*;

  logic seen_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ovf_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_ovf_i) begin
      seen_ovf_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Response valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sum_i) && $stable(out_ovf_i))
    else $error("Response payload changed while stalled.");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_ovf_q |-> out_ovf_i)
    else $error("Overflow flag cleared after it was reported.");

  a_sum_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_SUM) |=> !in_ready_i)
    else $error("Request taken while a sum request is in progress.");
endmodule

bind range_sum_with_point_updates rsum_checker u_rsum_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_opcode_i (req_i.opcode),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_sum_i   (rsp_o.range_sum),
  .out_ovf_i   (rsp_o.log_overflowed)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the range sum block with point updates.
// It walks a stimulus table, random traffic and a second table, and checks every sum.
// Depends on rsum_pkg, rsum_req_if, rsum_rsp_if and the range_sum_with_point_updates RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsum_pkg::*;

  localparam int unsigned ELEMENTS     = ELEMENTS_DEF;
  localparam int unsigned LOG_DEPTH    = LOG_DEPTH_DEF;
  localparam int          RAND_ITEMS   = 500;
  localparam int          GAP_MAX      = 12;
  localparam int          RX_STALL_MAX = 256;
  localparam int          HOLD_AFTER   = 14;
  localparam int          HOLD_CYCLES  = 5000;
  localparam int          FILL_UPDATES = LOG_DEPTH + 20;
  localparam longint      CYCLE_LIMIT  =
    4 * ((RAND_ITEMS + 40) * (LOG_DEPTH + 3 + GAP_MAX + RX_STALL_MAX)
         + (FILL_UPDATES + 40) * (GAP_MAX + 1) + HOLD_CYCLES);

  localparam logic signed [ACC_W-1:0] SAT_HI = $signed({2'b00, SUM_MAX});
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  typedef struct {
    opcode_e          op;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] end_idx;
    logic [AMT_W-1:0] amt;
  } req_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
  } sum_result_t;

  typedef struct {
    req_item_t   item;
    int          reps;
    bit          has_typed;
    sum_result_t result;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rsum_req_if req_if ();
  rsum_rsp_if rsp_if ();

  range_sum_with_point_updates #(
    .ELEMENTS (ELEMENTS),
    .LOG_DEPTH(LOG_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic signed [SUM_W-1:0]   prefix_sums [ELEMENTS];
  bit                        prefix_loaded [ELEMENTS];
  int unsigned               loaded_idx [$];
  logic signed [SUM_W-1:0]   running_total = '0;
  logic [IDX_W-1:0]          update_idx [LOG_DEPTH];
  logic signed [DELTA_W-1:0] update_delta [LOG_DEPTH];
  int unsigned               update_count = 0;
  logic                      updates_dropped = 1'b0;

  sum_result_t pending_sums [$];
  stim_row_t   stim_rows [$];
  sum_result_t no_typed_res = '{sum: '0, ovf: 1'b0};
  int          errors       = 0;
  int          results_seen = 0;
  int          burst_left   = 0;
  longint      cycle_count  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit apply_request(input req_item_t it, output sum_result_t res);
    logic signed [ACC_W-1:0]   acc;
    logic signed [DELTA_W-1:0] delta;
    res.sum = '0;
    res.ovf = 1'b0;
    case (it.op)
      OP_LOAD: begin
        acc = ACC_W'(running_total) + ACC_W'($signed({1'b0, it.amt}));
        if (acc > SAT_HI) acc = SAT_HI;
        running_total = acc[SUM_W-1:0];
        prefix_sums[it.start_idx] = running_total;
        if (!prefix_loaded[it.start_idx]) loaded_idx.push_back(it.start_idx);
        prefix_loaded[it.start_idx] = 1'b1;
      end
      OP_GIVE, OP_TAKE: begin
        delta = $signed({1'b0, it.amt});
        if (it.op == OP_TAKE) delta = -delta;
        if (update_count < LOG_DEPTH) begin
          update_idx[update_count]   = it.start_idx;
          update_delta[update_count] = delta;
          update_count++;
        end else begin
          updates_dropped = 1'b1;
        end
      end
      default: begin
        acc = ACC_W'(prefix_sums[it.end_idx]);
        if (it.start_idx != 0) acc = acc - ACC_W'(prefix_sums[it.start_idx - 1'b1]);
        for (int k = 0; k < update_count; k++) begin
          if (update_idx[k] >= it.start_idx && update_idx[k] <= it.end_idx) begin
            acc = acc + ACC_W'(update_delta[k]);
          end
        end
        if (acc > SAT_HI) acc = SAT_HI;
        else if (acc < SAT_LO) acc = SAT_LO;
        res.sum = acc[SUM_W-1:0];
        res.ovf = updates_dropped;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return IDX_W'(ELEMENTS - 1);
    return IDX_W'($urandom_range(0, ELEMENTS - 1));
  endfunction

  function automatic logic [AMT_W-1:0] random_amount();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // A query only ever reads prefix entries that have been loaded.
  function automatic req_item_t random_item();
    req_item_t   it;
    int          pick;
    int unsigned below;
    it.start_idx = random_index();
    it.end_idx   = random_index();
    it.amt       = random_amount();
    pick = $urandom_range(0, 99);
    if (pick < 35 || loaded_idx.size() == 0) it.op = OP_LOAD;
    else if (pick < 65) it.op = OP_SUM;
    else if (pick < 83) it.op = OP_GIVE;
    else it.op = OP_TAKE;
    if (it.op == OP_SUM) begin
      it.end_idx = IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
      below = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
      if (below == ELEMENTS - 1 || $urandom_range(0, 4) == 0) it.start_idx = '0;
      else it.start_idx = IDX_W'(below + 1);
    end
    return it;
  endfunction

  function automatic void add_row(opcode_e op, int s, int e, logic [AMT_W-1:0] amt,
                                  int reps = 1, bit has_typed = 1'b0,
                                  logic signed [SUM_W-1:0] sum = '0, logic ovf = 1'b0);
    stim_row_t row;
    row.item.op        = op;
    row.item.start_idx = IDX_W'(s);
    row.item.end_idx   = IDX_W'(e);
    row.item.amt       = amt;
    row.reps           = reps;
    row.has_typed      = has_typed;
    row.result.sum     = sum;
    row.result.ovf     = ovf;
    stim_rows.push_back(row);
  endfunction

  task automatic send_item(input req_item_t it, input bit has_typed,
                           input sum_result_t typed_res);
    sum_result_t res;
    int          gap;
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.opcode      <= it.op;
    req_if.start_index <= it.start_idx;
    req_if.end_index   <= it.end_idx;
    req_if.amount      <= it.amt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (apply_request(it, res)) begin
      if (has_typed) pending_sums.push_back(typed_res);
      else pending_sums.push_back(res);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid  <= 1'b0;
        req_if.amount <= $urandom;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic walk_rows();
    stim_row_t row;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      repeat (row.reps) begin
        if (row.item.op == OP_SUM) row.item.amt = $urandom;
        else row.item.end_idx = IDX_W'($urandom_range(0, ELEMENTS - 1));
        send_item(row.item, row.has_typed, row.result);
      end
    end
  endtask

  initial begin
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_LOAD;
    req_if.start_index <= '0;
    req_if.end_index   <= '0;
    req_if.amount      <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_row(OP_LOAD, 0, 0, '0);
    add_row(OP_SUM, 0, 0, '0, 1, 1'b1, 48'sd0, 1'b0);
    add_row(OP_LOAD, 1, 0, '1);
    add_row(OP_SUM, 1, 1, '0, 1, 1'b1, 48'sd4294967295, 1'b0);
    add_row(OP_SUM, 0, 1, '0, 1, 1'b1, 48'sd4294967295, 1'b0);
    add_row(OP_LOAD, ELEMENTS - 1, 0, 32'd5);
    add_row(OP_SUM, 2, ELEMENTS - 1, '0, 1, 1'b1, 48'sd5, 1'b0);
    add_row(OP_SUM, 2, 0, '0, 1, 1'b1, -48'sd4294967295, 1'b0);
    add_row(OP_GIVE, 0, 0, '1);
    add_row(OP_TAKE, ELEMENTS - 1, 0, '1);
    add_row(OP_GIVE, 1, 0, 32'd1);
    add_row(OP_TAKE, 512, 0, '0);
    add_row(OP_GIVE, ELEMENTS - 1, 0, 32'h8000_0000);
    add_row(OP_SUM, 0, ELEMENTS - 1, '0);
    add_row(OP_SUM, 1, 1, '0);
    add_row(OP_SUM, 2, 0, '0);
    add_row(OP_LOAD, 700, 0, 32'h8000_0000);
    add_row(OP_SUM, 701, ELEMENTS - 1, '0);
    add_row(OP_SUM, 1, 700, '0);
    walk_rows();

    repeat (RAND_ITEMS) send_item(random_item(), 1'b0, no_typed_res);

    // Fill the update log just past its depth so that later updates are dropped.
    add_row(OP_GIVE, 0, 0, '1, int'(LOG_DEPTH - update_count) + 4);
    add_row(OP_SUM, 0, ELEMENTS - 1, '0);
    add_row(OP_TAKE, ELEMENTS - 1, 0, 32'd1, 3);
    add_row(OP_SUM, 0, ELEMENTS - 1, '0);
    add_row(OP_LOAD, 0, 0, 32'd7);
    add_row(OP_SUM, 1, ELEMENTS - 1, '0);
    add_row(OP_SUM, 2, 0, '0);
    walk_rows();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (LOG_DEPTH + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : drive_rsp_ready
    rx_mode_e    mode;
    int          mode_left;
    int          hold_left;
    bit          held;
    logic [15:0] pattern;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    pattern   = '1;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 200);
          pattern   = 16'($urandom);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  rsp_if.ready <= 1'b1;
          RX_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
          default:  rsp_if.ready <= pattern[mode_left % 16];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sum_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: result with no pending sum request, expected none, got %0d",
                 $time, rsp_if.range_sum);
      end else begin
        want = pending_sums.pop_front();
        if (rsp_if.range_sum !== want.sum) begin
          errors++;
          $display("%0t: range_sum expected %0d, got %0d", $time, want.sum, rsp_if.range_sum);
        end
        if (rsp_if.log_overflowed !== want.ovf) begin
          errors++;
          $display("%0t: log_overflowed expected %0b, got %0b",
                   $time, want.ovf, rsp_if.log_overflowed);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
